// ===== sv/srt_pkg.sv =====
`timescale 1ns / 1ps

package srt_pkg;

    localparam int NAME_BYTES = 9;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 112;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_LISTED    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ROTATE = 2'd3
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_LIST = 2'd2
    } state_t;

    typedef struct packed {
        logic [63:0]        name_head;
        logic [7:0]         name_tail;
        logic signed [31:0] id;
    } rec_t;

    // broadcast to every cell each cycle
    typedef struct packed {
        cell_cmd_t cmd;
        rec_t      rec_new;
    } cell_ctl_t;

    // zero every byte from the first zero byte on, and past NAME_BYTES
    function automatic logic [71:0] clean_name(input logic [63:0] head, input logic [7:0] tail);
        logic [71:0] raw;
        logic [71:0] res;
        logic        alive;
        raw   = {head, tail};
        res   = '0;
        alive = 1'b1;
        for (int k = 0; k < 9; k++) begin
            alive = alive && (raw[71-8*k -: 8] != 8'd0) && (k < NAME_BYTES);
            if (alive) begin
                res[71-8*k -: 8] = raw[71-8*k -: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/srt_cell.sv =====
`timescale 1ns / 1ps

module srt_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic              aclk,
    input  srt_pkg::cell_ctl_t ctl,
    input  logic              valid_in,
    input  logic              prev_valid,
    input  logic              prev_flag,
    input  srt_pkg::rec_t     prev_rec,
    input  logic              next_valid,
    input  srt_pkg::rec_t     next_rec,
    input  srt_pkg::rec_t     head_rec,
    input  logic              gone_in,
    output logic              flag_o,
    output logic              gone_o,
    output logic              hit_o,
    output srt_pkg::rec_t     rec_o
);
    import srt_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic [71:0] own_name;
    logic [71:0] new_name;
    logic        less;
    logic        equal;
    logic        match;

    assign own_name = {rec_reg.name_head, rec_reg.name_tail};
    assign new_name = {ctl.rec_new.name_head, ctl.rec_new.name_tail};
    assign less     = new_name < own_name;
    assign equal    = new_name == own_name;

    // head goes strictly before; others before an equal name too
    assign flag_o = valid_in && (less || (!IS_HEAD && equal));
    assign match  = valid_in && (rec_reg.id == ctl.rec_new.id);
    assign gone_o = gone_in || match;
    assign hit_o  = match && !gone_in;
    assign rec_o  = rec_reg;

    always_comb begin
        rec_next = rec_reg;
        case (ctl.cmd)
            CMD_INSERT: begin
                if (prev_flag) begin
                    rec_next = prev_rec;
                end else if (flag_o || (!valid_in && prev_valid)) begin
                    rec_next = ctl.rec_new;
                end
            end
            CMD_REMOVE: begin
                if (gone_o) begin
                    rec_next = next_rec;
                end
            end
            CMD_ROTATE: begin
                if (valid_in) begin
                    rec_next = next_valid ? next_rec : head_rec;
                end
            end
            default: rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

// ===== sv/sorted_record_table.sv =====
`timescale 1ns / 1ps
// Insert and remove: the command word is taken in IDLE, handled in EXEC, and the reply
//   word goes to the output register; a listing passes IDLE, EXEC, then LIST.
// No new command word is taken until the block is back in IDLE; a listing sends
//   one entry word per cycle unless the output stalls, set by the cell chain rotation.
// Reset (aresetn low, synchronous): table empties, output channel goes idle.
// No clearing pass; the block is ready in the first cycle after reset.

module sorted_record_table #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: opcode[1:0], name_head[65:2], name_tail[73:66], student_id[105:74]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srt_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: status[2:0], out_name_head[66:3], out_name_tail[74:67], out_id[106:75]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import srt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // control
    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    rec_t       in_rec_reg, in_rec_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;

    // output word register
    logic       m_valid_reg, m_valid_next;
    status_t    m_status_reg, m_status_next;
    rec_t       m_rec_reg, m_rec_next;
    logic       m_last_reg, m_last_next;

    // chain
    cell_ctl_t  ctl;
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_flag;
    logic [DEPTH-1:0] cell_gone;
    logic [DEPTH-1:0] cell_hit;
    rec_t       cell_rec [DEPTH];
    rec_t       hit_rec;
    logic       out_free;
    logic [71:0] clean_in;

    assign clean_in = clean_name(s_tdata[65:2], s_tdata[73:66]);

    // occupancy comes from the count: cells below it hold live entries
    for (genvar i = 0; i < DEPTH; i++) begin : g_valid
        assign cell_valid[i] = CNT_W'(i) < count_reg;
    end

    // Each cell compares the new name against its own entry and either keeps
    // it, pulls from its left neighbor (insert), its right neighbor
    // (remove / rotate; the last live cell takes the head) or loads the new record.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            srt_cell #(.IS_HEAD(1'b1)) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .valid_in   (cell_valid[i]),
                .prev_valid (1'b1),
                .prev_flag  (1'b0),
                .prev_rec   ('0),
                .next_valid (cell_valid[i+1]),
                .next_rec   (cell_rec[i+1]),
                .head_rec   (cell_rec[0]),
                .gone_in    (1'b0),
                .flag_o     (cell_flag[i]),
                .gone_o     (cell_gone[i]),
                .hit_o      (cell_hit[i]),
                .rec_o      (cell_rec[i])
            );
        end else if (i == DEPTH - 1) begin : g_tail
            srt_cell #(.IS_HEAD(1'b0)) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .valid_in   (cell_valid[i]),
                .prev_valid (cell_valid[i-1]),
                .prev_flag  (cell_flag[i-1]),
                .prev_rec   (cell_rec[i-1]),
                .next_valid (1'b0),
                .next_rec   (cell_rec[0]),
                .head_rec   (cell_rec[0]),
                .gone_in    (cell_gone[i-1]),
                .flag_o     (cell_flag[i]),
                .gone_o     (cell_gone[i]),
                .hit_o      (cell_hit[i]),
                .rec_o      (cell_rec[i])
            );
        end else begin : g_mid
            srt_cell #(.IS_HEAD(1'b0)) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .valid_in   (cell_valid[i]),
                .prev_valid (cell_valid[i-1]),
                .prev_flag  (cell_flag[i-1]),
                .prev_rec   (cell_rec[i-1]),
                .next_valid (cell_valid[i+1]),
                .next_rec   (cell_rec[i+1]),
                .head_rec   (cell_rec[0]),
                .gone_in    (cell_gone[i-1]),
                .flag_o     (cell_flag[i]),
                .gone_o     (cell_gone[i]),
                .hit_o      (cell_hit[i]),
                .rec_o      (cell_rec[i])
            );
        end
    end

    // at most one cell reports the first id match
    always_comb begin
        hit_rec = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_hit[i]) begin
                hit_rec = hit_rec | cell_rec[i];
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        in_rec_next   = in_rec_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_rec_next    = m_rec_reg;
        m_last_next   = m_last_reg;
        ctl.cmd       = CMD_HOLD;
        ctl.rec_new   = in_rec_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next               = s_tdata[1:0];
                    in_rec_next.name_head = clean_in[71:8];
                    in_rec_next.name_tail = clean_in[7:0];
                    in_rec_next.id        = s_tdata[105:74];
                    state_next            = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next    = S_IDLE;
                    m_rec_next    = '0;
                    m_last_next   = 1'b1;
                    m_valid_next  = 1'b1;
                    case (op_reg)
                        OP_INSERT: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                m_status_next = ST_FULL;
                            end else begin
                                ctl.cmd       = CMD_INSERT;
                                count_next    = count_reg + CNT_W'(1);
                                m_status_next = ST_INSERTED;
                            end
                        end
                        OP_REMOVE: begin
                            if (count_reg == '0) begin
                                m_status_next = ST_EMPTY;
                            end else if (cell_gone[DEPTH-1]) begin
                                ctl.cmd       = CMD_REMOVE;
                                count_next    = count_reg - CNT_W'(1);
                                m_status_next = ST_REMOVED;
                                m_rec_next    = hit_rec;
                            end else begin
                                m_status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                // entries go out from the LIST state
                                m_valid_next = m_valid_reg && !m_tready;
                                left_next    = count_reg;
                                state_next   = S_LIST;
                            end
                        end
                        default: begin
                            // undefined opcode: no word, no change
                            m_valid_next = m_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            S_LIST: begin
                // head of the chain goes out, chain rotates by one;
                // after count rotations the order is back where it began
                if (out_free) begin
                    ctl.cmd       = CMD_ROTATE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_LISTED;
                    m_rec_next    = cell_rec[0];
                    m_last_next   = (left_reg == CNT_W'(1));
                    left_next     = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        in_rec_reg   <= in_rec_next;
        m_status_reg <= m_status_next;
        m_rec_reg    <= m_rec_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b0, m_rec_reg.id, m_rec_reg.name_tail, m_rec_reg.name_head,
                       m_status_reg};

endmodule

// ===== sv/srt_checker.sv =====
`timescale 1ns / 1ps

module srt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [srt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import srt_pkg::*;

    logic [2:0] st;
    assign st = m_tdata[2:0];

    // output channel idle right after reset
    a_reset_idle: assert property (@(posedge aclk) !$past(aresetn) |-> !m_tvalid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st <= ST_LISTED)
        else $error("unknown status code");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != ST_LISTED |-> m_tlast)
        else $error("status word without last");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_INSERTED || st == ST_NOT_FOUND || st == ST_EMPTY ||
                     st == ST_FULL) |-> m_tdata[106:3] == '0)
        else $error("status word carries a record");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/sorted_record_table_tb.sv =====
`timescale 1ns / 1ps

module sorted_record_table_tb;
    import srt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 42;    // counted words per random phase, op 3 excluded

    // opcode the block drops without a reply
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        status_t     status;
        logic [63:0] head;
        logic [7:0]  tail;
        logic [31:0] id;
        logic        last;
    } reply_t;

    // Shadow copy of the sorted table. Each accepted command word updates it and
    // queues the reply words the block owes; each reply word pops the oldest one.
    class shadow_table;
        logic [71:0] names [TABLE_DEPTH];   // {head, tail}, already trimmed
        logic [31:0] ids [TABLE_DEPTH];
        int          count;
        reply_t      pending_replies[$];
        int          errors;
        int          taken;
        int          checked;
        int          seen [6];

        function new();
            count   = 0;
            errors  = 0;
            taken   = 0;
            checked = 0;
            foreach (seen[k]) seen[k] = 0;
        endfunction

        // name ends at its first zero byte; bytes past NAME_BYTES are dropped too
        function logic [71:0] trim_name(logic [71:0] raw);
            logic [71:0] kept;
            logic        alive;
            kept  = '0;
            alive = 1'b1;
            for (int k = 0; k < 9; k++) begin
                if (raw[71 - 8*k -: 8] == 8'd0 || k >= NAME_BYTES) alive = 1'b0;
                if (alive) kept[71 - 8*k -: 8] = raw[71 - 8*k -: 8];
            end
            return kept;
        endfunction

        function void owe(status_t st, logic [71:0] name, logic [31:0] id, logic last);
            reply_t r;
            r.status = st;
            r.head   = name[71:8];
            r.tail   = name[7:0];
            r.id     = id;
            r.last   = last;
            pending_replies.push_back(r);
        endfunction

        function void take_command(logic [1:0] op, logic [71:0] raw, logic [31:0] id);
            logic [71:0] name;
            int          pos;
            taken++;
            case (op)
                OP_INSERT: begin
                    if (count >= TABLE_DEPTH) begin
                        owe(ST_FULL, '0, '0, 1'b1);
                    end else begin
                        name = trim_name(raw);
                        // equal to the head lands just after it; otherwise
                        // before the first entry that is not smaller
                        pos = 0;
                        if (count != 0 && name >= names[0]) begin
                            pos = 1;
                            while (pos < count && name > names[pos]) pos++;
                        end
                        for (int i = count; i > pos; i--) begin
                            names[i] = names[i - 1];
                            ids[i]   = ids[i - 1];
                        end
                        names[pos] = name;
                        ids[pos]   = id;
                        count++;
                        owe(ST_INSERTED, '0, '0, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    if (count == 0) begin
                        owe(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        pos = 0;
                        while (pos < count && ids[pos] != id) pos++;
                        if (pos == count) begin
                            owe(ST_NOT_FOUND, '0, '0, 1'b1);
                        end else begin
                            owe(ST_REMOVED, names[pos], ids[pos], 1'b1);
                            for (int i = pos; i + 1 < count; i++) begin
                                names[i] = names[i + 1];
                                ids[i]   = ids[i + 1];
                            end
                            count--;
                        end
                    end
                end
                OP_LIST: begin
                    if (count == 0) begin
                        owe(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < count; i++)
                            owe(ST_LISTED, names[i], ids[i], i == count - 1);
                    end
                end
                default: ;  // OP_IGNORED: no reply, no change
            endcase
        endfunction

        function void check_word(logic [2:0] st, logic [63:0] h, logic [7:0] t,
                                 logic [31:0] id, logic last);
            reply_t want;
            checked++;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: reply word with none expected, got status %0d id %0d",
                         $time, st, $signed(id));
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status || h !== want.head || t !== want.tail ||
                id !== want.id || last !== want.last) begin
                errors++;
                $display("%0t: st/name/id/last expected %0d %h_%h %0d %b, got %0d %h_%h %0d %b",
                         $time, want.status, want.head, want.tail, $signed(want.id),
                         want.last, st, h, t, $signed(id), last);
            end else begin
                seen[st]++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    bit                   calm       = 1'b0;   // phase with no idling on either side
    int                   stall_left = 0;

    shadow_table table_model = new();

    sorted_record_table #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run guard: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout, %0d reply words still owed", table_model.pending_replies.size());
        $display("Simulation FAILED");
        $finish;
    end

    // sender gap: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side back-pressure, same shape as the sender gaps.
    always @(posedge aclk) begin : rx_pace
        int r;
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= (r < 92) ? $urandom_range(0, 2) : $urandom_range(7, 29);
            end
        end
    end

    // Result monitor: m_tdata = status[2:0], name head[66:3], tail[74:67], id[106:75]
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            table_model.check_word(m_tdata[2:0], m_tdata[66:3], m_tdata[74:67],
                                   m_tdata[106:75], m_tlast);
    end

    // Present one command word, hold it until taken, then maybe idle.
    // Valid is only dropped when a gap follows, never lowered and raised in one step.
    task automatic send_word(input logic [1:0] op, input logic [71:0] name,
                             input logic [31:0] id);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 106){1'b0}}, id, name[7:0], name[71:8], op};
        do @(posedge aclk); while (!s_tready);
        table_model.take_command(op, name, id);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // short names leave byte 5 zero, so the low bytes can carry junk past the end
    function automatic logic [71:0] short_name(int k);
        case (k)
            0:       return {"ANN", 48'd0};
            1:       return {"BOB", 48'd0};
            2:       return {"CARLA", 32'd0};
            3:       return {"AL", 56'd0};
            4:       return {"ZOE", 48'd0};
            default: return {"BOBBY", 32'd0};
        endcase
    endfunction

    function automatic logic [71:0] pick_name();
        logic [71:0] name;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            name = short_name($urandom_range(0, 5));
            if ($urandom_range(0, 1)) name[23:0] = 24'($urandom);
        end else if (r < 55 && table_model.count > 0) begin
            // exact copy of a stored name: ties with head or inner entries
            name = table_model.names[$urandom_range(0, table_model.count - 1)];
        end else begin
            name = {$urandom, $urandom, 8'($urandom)};
            if ($urandom_range(0, 2) == 0) name[71 - 8*$urandom_range(0, 8) -: 8] = 8'h00;
        end
        return name;
    endfunction

    // small ids repeat often so removal has to take the first match in order
    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7);
            1:       return -$urandom_range(1, 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] remove_id();
        if (table_model.count > 0 && $urandom_range(0, 99) < 70)
            return table_model.ids[$urandom_range(0, table_model.count - 1)];
        return pick_id();
    endfunction

    initial begin
        int r;
        int sent;
        int ins_pct;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        send_word(OP_LIST, '0, 32'd0);                           // list of empty table
        send_word(OP_REMOVE, '0, 32'd5);                         // remove from empty table
        send_word(OP_INSERT, {"BOB", 48'd0}, 32'd1);
        send_word(OP_INSERT, {72{1'b1}}, 32'h7FFF_FFFF);         // largest name, max id
        send_word(OP_INSERT, 72'd0, 32'h8000_0000);              // empty name, min id -> head
        send_word(OP_INSERT, {"AL", 8'h00, "XYZQW", 8'h55}, 32'd0); // junk after terminator
        send_word(OP_INSERT, 72'd0, 32'd7);                      // ties head, goes after it
        send_word(OP_INSERT, {"BOB", 8'h00, 40'h1234567890}, 32'd2); // ties inner entry
        send_word(OP_INSERT, {"ABCDEFGH", "I"}, 32'hFFFF_FFFF);  // all nine bytes used
        send_word(OP_REMOVE, '0, 32'd12345);                     // id not present
        send_word(OP_REMOVE, '0, 32'd2);                         // inner entry
        send_word(OP_REMOVE, '0, 32'h8000_0000);                 // head entry
        send_word(OP_LIST, '0, 32'd0);
        send_word(OP_IGNORED, {72{1'b1}}, 32'hFFFF_FFFF);
        while (table_model.count < TABLE_DEPTH)
            send_word(OP_INSERT, pick_name(), pick_id());
        send_word(OP_INSERT, {"ZOE", 48'd0}, 32'd9);             // table full
        send_word(OP_LIST, '0, 32'd0);                           // full listing
        send_word(OP_REMOVE, '0, table_model.ids[TABLE_DEPTH - 1]); // tail entry

        // --- random part: fill-heavy and drain-heavy phases alternate ---
        for (int ph = 0; ph < PHASES; ph++) begin
            calm    <= (ph % 3 == 2);
            ins_pct = (ph % 2 == 0) ? 80 : 25;
            sent    = 0;
            while (sent < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_word(OP_IGNORED, pick_name(), $urandom);
                end else begin
                    if (r < 13)
                        send_word(OP_LIST, pick_name(), pick_id());
                    else if ($urandom_range(0, 99) < ins_pct)
                        send_word(OP_INSERT, pick_name(), pick_id());
                    else
                        send_word(OP_REMOVE, pick_name(), remove_id());
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (table_model.pending_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);    // catch any stray trailing word

        $display("Covered %0d command words and %0d reply words, %0d bad.",
                 table_model.taken, table_model.checked, table_model.errors);
        $display("Good replies: ins %0d rem %0d absent %0d empty %0d full %0d listed %0d",
                 table_model.seen[ST_INSERTED], table_model.seen[ST_REMOVED],
                 table_model.seen[ST_NOT_FOUND], table_model.seen[ST_EMPTY],
                 table_model.seen[ST_FULL], table_model.seen[ST_LISTED]);
        if (table_model.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/srt_pkg.sv
sv/srt_cell.sv
sv/sorted_record_table.sv
sv/srt_checker.sv
tb/sorted_record_table_tb.sv
